// ----- sv/cyclic_word_pair_canonicalizer_macros.svh -----
// assertion macros used by the rtl (cwpc_ctrl)
`ifndef CYCLIC_WORD_PAIR_CANONICALIZER_MACROS_SVH
`define CYCLIC_WORD_PAIR_CANONICALIZER_MACROS_SVH

`ifndef SYNTHESIS
`define CWPC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cwpc assertion failed");
`define CWPC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("cwpc assertion failed");
`else
`define CWPC_ASSERT(name, clk, rst_n, prop)
`define CWPC_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- sv/cwpc_pkg.sv -----
`default_nettype none

package cwpc_pkg;

  localparam int MAX_LETTERS = 32;
  localparam int CODE_W      = 2 * MAX_LETTERS;
  localparam int LEN_W       = 6;
  localparam int NUM_SYM     = 8;

  typedef logic [CODE_W-1:0]               code_t;
  typedef logic [LEN_W-1:0]                len_t;
  typedef logic [2:0]                      sym_idx_t;
  typedef logic [4:0]                      rot_idx_t;
  typedef logic [NUM_SYM-1:0][CODE_W-1:0]  code_set_t;

  localparam code_t    EMPTY_CODE = '1;
  localparam code_t    INV_FLIP   = {MAX_LETTERS{2'b01}};
  localparam sym_idx_t SEL_LAST   = sym_idx_t'(NUM_SYM - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_SELECT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic     load;
    logic     rotate;
    rot_idx_t rot_idx;
    logic     select;
    sym_idx_t sel_idx;
    logic     sel_first;
    logic     out_load;
  } ctrl_t;

  // field order gives the lexicographic compare
  typedef struct packed {
    len_t  short_length;
    code_t short_code;
    len_t  long_length;
    code_t long_code;
  } pair_t;

  function automatic len_t clamp_len(input len_t n);
    return (n > len_t'(MAX_LETTERS)) ? len_t'(MAX_LETTERS) : n;
  endfunction

  function automatic code_t len_mask(input len_t n);
    return ~(EMPTY_CODE << {n, 1'b0});
  endfunction

  // inverse word: letters reversed, each sign flipped
  function automatic code_t rev_inv(input code_t w, input len_t n);
    code_t r;
    for (int i = 0; i < MAX_LETTERS; i++) begin
      r[2*i +: 2] = w[2*(MAX_LETTERS-1-i) +: 2];
    end
    r = r >> (7'(CODE_W) - {n, 1'b0});
    return (r ^ INV_FLIP) & len_mask(n);
  endfunction

  // cyclic shift by one letter within n letters
  function automatic code_t rot_letter(input code_t v, input len_t n);
    code_t top;
    top = v >> ({n, 1'b0} - 7'd2);
    return ((v << 2) & len_mask(n)) | {{(CODE_W-2){1'b0}}, top[1:0]};
  endfunction

  // letter image for each symmetry, packed {map(3), map(2), map(1), map(0)}
  function automatic logic [7:0] sym_row(input sym_idx_t k);
    logic [7:0] row;
    case (k)
      3'd0:    row = {2'd3, 2'd2, 2'd1, 2'd0};
      3'd1:    row = {2'd2, 2'd3, 2'd1, 2'd0};
      3'd2:    row = {2'd3, 2'd2, 2'd0, 2'd1};
      3'd3:    row = {2'd2, 2'd3, 2'd0, 2'd1};
      3'd4:    row = {2'd1, 2'd0, 2'd3, 2'd2};
      3'd5:    row = {2'd0, 2'd1, 2'd3, 2'd2};
      3'd6:    row = {2'd1, 2'd0, 2'd2, 2'd3};
      3'd7:    row = {2'd0, 2'd1, 2'd2, 2'd3};
      default: row = {2'd3, 2'd2, 2'd1, 2'd0};
    endcase
    return row;
  endfunction

  function automatic code_t map_code(input code_t v, input sym_idx_t k);
    logic [7:0] row;
    code_t      m;
    row = sym_row(k);
    for (int i = 0; i < MAX_LETTERS; i++) begin
      m[2*i +: 2] = row[{v[2*i +: 2], 1'b0} +: 2];
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cwpc_req_if.sv -----
`default_nettype none

interface cwpc_req_if;
  import cwpc_pkg::*;

  logic  valid;
  logic  ready;
  code_t first_word;
  len_t  first_length;
  code_t second_word;
  len_t  second_length;

  modport source (
    output valid, first_word, first_length, second_word, second_length,
    input  ready
  );

  modport sink (
    input  valid, first_word, first_length, second_word, second_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/cwpc_rsp_if.sv -----
`default_nettype none

interface cwpc_rsp_if;
  import cwpc_pkg::*;

  logic  valid;
  logic  ready;
  code_t short_code;
  len_t  short_length;
  code_t long_code;
  len_t  long_length;

  modport source (
    output valid, short_code, short_length, long_code, long_length,
    input  ready
  );

  modport sink (
    input  valid, short_code, short_length, long_code, long_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/cwpc_ctrl.sv -----
`default_nettype none
`include "cyclic_word_pair_canonicalizer_macros.svh"

module cwpc_ctrl import cwpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  len_t  n_max_i,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  output ctrl_t ctrl_o
);

  state_e   state_q, state_d;
  rot_idx_t rot_cnt_q, rot_cnt_d;
  sym_idx_t sel_cnt_q, sel_cnt_d;
  len_t     n_max_q, n_max_d;
  logic     out_valid_q, out_valid_d;
  logic     accept;
  logic     rot_last;
  logic     out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign rot_last = ({1'b0, rot_cnt_q} == (n_max_q - 6'd1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    rot_cnt_d = rot_cnt_q;
    sel_cnt_d = sel_cnt_q;
    n_max_d   = n_max_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_max_d   = n_max_i;
          rot_cnt_d = '0;
          sel_cnt_d = '0;
          state_d   = (n_max_i == '0) ? ST_SELECT : ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        rot_cnt_d = rot_cnt_q + 1'b1;
        if (rot_last) begin
          state_d = ST_SELECT;
        end
      end
      ST_SELECT: begin
        sel_cnt_d = sel_cnt_q + 1'b1;
        if (sel_cnt_q == SEL_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    ctrl_o.load      = accept;
    ctrl_o.rotate    = (state_q == ST_ROTATE);
    ctrl_o.rot_idx   = rot_cnt_q;
    ctrl_o.select    = (state_q == ST_SELECT);
    ctrl_o.sel_idx   = sel_cnt_q;
    ctrl_o.sel_first = (sel_cnt_q == '0);
    ctrl_o.out_load  = (state_q == ST_EMIT) && out_free;
    out_valid_d      = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rot_cnt_q   <= '0;
      sel_cnt_q   <= '0;
      n_max_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rot_cnt_q   <= rot_cnt_d;
      sel_cnt_q   <= sel_cnt_d;
      n_max_q     <= n_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CWPC_ASSERT(a_accept_starts_work, clk_i, rst_ni, accept |=> (state_q == ST_ROTATE || state_q == ST_SELECT))
  `CWPC_ASSERT(a_rot_in_range, clk_i, rst_ni, (state_q == ST_ROTATE) |-> ({1'b0, rot_cnt_q} < n_max_q))
  `CWPC_ASSERT(a_result_after_select, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
  `CWPC_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_q)

endmodule

`default_nettype wire

// ----- sv/cwpc_rot_min.sv -----
`default_nettype none

module cwpc_rot_min import cwpc_pkg::*; (
  input  logic      clk_i,
  input  ctrl_t     ctrl_i,
  input  code_t     word_a_i,
  input  len_t      len_a_i,
  input  code_t     word_b_i,
  input  len_t      len_b_i,
  output code_set_t min_a_o,
  output code_set_t min_b_o,
  output len_t      len_a_o,
  output len_t      len_b_o
);

  code_t     fwd_a_q, inv_a_q, fwd_b_q, inv_b_q;
  len_t      len_a_q, len_b_q;
  code_set_t min_a_q, min_b_q;
  code_set_t min_a_d, min_b_d;
  code_t     mask_a, mask_b;
  logic      act_a, act_b;

  assign mask_a = len_mask(len_a_q);
  assign mask_b = len_mask(len_b_q);
  assign act_a  = ({1'b0, ctrl_i.rot_idx} < len_a_q);
  assign act_b  = ({1'b0, ctrl_i.rot_idx} < len_b_q);

  always_comb begin
    code_t fa, ra, fb, rb, ca, cb;
    min_a_d = min_a_q;
    min_b_d = min_b_q;
    for (int k = 0; k < NUM_SYM; k++) begin
      fa = map_code(fwd_a_q, sym_idx_t'(k)) & mask_a;
      ra = map_code(inv_a_q, sym_idx_t'(k)) & mask_a;
      fb = map_code(fwd_b_q, sym_idx_t'(k)) & mask_b;
      rb = map_code(inv_b_q, sym_idx_t'(k)) & mask_b;
      ca = (fa < ra) ? fa : ra;
      cb = (fb < rb) ? fb : rb;
      if (act_a && (ca < min_a_q[k])) begin
        min_a_d[k] = ca;
      end
      if (act_b && (cb < min_b_q[k])) begin
        min_b_d[k] = cb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      len_a_q <= len_a_i;
      len_b_q <= len_b_i;
      fwd_a_q <= word_a_i & len_mask(len_a_i);
      inv_a_q <= rev_inv(word_a_i, len_a_i);
      fwd_b_q <= word_b_i & len_mask(len_b_i);
      inv_b_q <= rev_inv(word_b_i, len_b_i);
      min_a_q <= {NUM_SYM{EMPTY_CODE}};
      min_b_q <= {NUM_SYM{EMPTY_CODE}};
    end else if (ctrl_i.rotate) begin
      fwd_a_q <= rot_letter(fwd_a_q, len_a_q);
      inv_a_q <= rot_letter(inv_a_q, len_a_q);
      fwd_b_q <= rot_letter(fwd_b_q, len_b_q);
      inv_b_q <= rot_letter(inv_b_q, len_b_q);
      min_a_q <= min_a_d;
      min_b_q <= min_b_d;
    end
  end

  assign min_a_o  = min_a_q;
  assign min_b_o  = min_b_q;
  assign len_a_o  = len_a_q;
  assign len_b_o  = len_b_q;

endmodule

`default_nettype wire

// ----- sv/cwpc_pair_sel.sv -----
`default_nettype none

module cwpc_pair_sel import cwpc_pkg::*; (
  input  logic      clk_i,
  input  ctrl_t     ctrl_i,
  input  code_set_t min_a_i,
  input  code_set_t min_b_i,
  input  len_t      len_a_i,
  input  len_t      len_b_i,
  output pair_t     result_o
);

  pair_t best_q;
  pair_t out_q;
  pair_t cand;
  code_t code_a, code_b;
  logic  swap;

  assign code_a = min_a_i[ctrl_i.sel_idx];
  assign code_b = min_b_i[ctrl_i.sel_idx];
  assign swap   = (len_b_i < len_a_i) || ((len_b_i == len_a_i) && (code_b < code_a));

  always_comb begin
    if (swap) begin
      cand = '{short_length: len_b_i, short_code: code_b,
               long_length: len_a_i, long_code: code_a};
    end else begin
      cand = '{short_length: len_a_i, short_code: code_a,
               long_length: len_b_i, long_code: code_b};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.select && (ctrl_i.sel_first || (cand < best_q))) begin
      best_q <= cand;
    end
    if (ctrl_i.out_load) begin
      out_q <= best_q;
    end
  end

  assign result_o = out_q;

endmodule

`default_nettype wire

// ----- sv/cyclic_word_pair_canonicalizer.sv -----
// cyclic word pair canonicalizer
//
// req_i carries two cyclic words over x, X, y, Y, two bits a letter with the
// first letter highest, and their lengths (above 32 counts as 32). rsp_o
// returns the least (length, code) ordered pair over the eight generator
// swaps and sign flips, each word taken at its least rotation of itself or
// its inverse; an empty word reads as all ones.
//
// one request is worked at a time: req_i.ready is high only while idle.
// after acceptance the rotation loop steps through max(first_length,
// second_length) rotations, one rotation per cycle with all eight
// symmetries, both words and both directions compared in parallel; the
// pair select unit then walks the eight symmetries, and the result then
// moves to the output register. a waiting result sits in its own
// register, so the next request is taken while rsp_o stalls; a finished
// request then waits until rsp_o frees. reset clears the sequencer and
// the result valid; no clearing pass.

`default_nettype none

module cyclic_word_pair_canonicalizer import cwpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cwpc_req_if.sink   req_i,
  cwpc_rsp_if.source rsp_o
);

  ctrl_t     ctrl;
  len_t      len_a_in, len_b_in, n_max;
  code_set_t min_a, min_b;
  len_t      len_a, len_b;
  pair_t     result;
  logic      out_valid;
  logic      in_ready;

  assign len_a_in = clamp_len(req_i.first_length);
  assign len_b_in = clamp_len(req_i.second_length);
  assign n_max    = (len_a_in > len_b_in) ? len_a_in : len_b_in;

  cwpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .n_max_i     (n_max),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (out_valid),
    .ctrl_o      (ctrl)
  );

  cwpc_rot_min u_rot_min (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .word_a_i (req_i.first_word),
    .len_a_i  (len_a_in),
    .word_b_i (req_i.second_word),
    .len_b_i  (len_b_in),
    .min_a_o  (min_a),
    .min_b_o  (min_b),
    .len_a_o  (len_a),
    .len_b_o  (len_b)
  );

  cwpc_pair_sel u_pair_sel (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .min_a_i  (min_a),
    .min_b_i  (min_b),
    .len_a_i  (len_a),
    .len_b_i  (len_b),
    .result_o (result)
  );

  assign req_i.ready        = in_ready;
  assign rsp_o.valid        = out_valid;
  assign rsp_o.short_code   = result.short_code;
  assign rsp_o.short_length = result.short_length;
  assign rsp_o.long_code    = result.long_code;
  assign rsp_o.long_length  = result.long_length;

endmodule

`default_nettype wire
